// ===== hdl/i2cee_pkg.sv =====
// Shared types, codes and the transaction program table for the I2C EEPROM master.
`timescale 1ns / 1ps

package i2cee_pkg;

    // Request codes carried on the operation field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_DEV_ADDR  = 1'b0;
    localparam logic REG_WORD_ADDR = 1'b1;

    // Register reset values
    localparam logic [6:0] DEV_ADDR_RESET  = 7'd80;
    localparam logic [7:0] WORD_ADDR_RESET = 8'd0;

    // Bus phase kinds that make up a transaction
    typedef enum logic [3:0] {
        K_NONE    = 4'd0,
        K_START   = 4'd1,
        K_SEND_AW = 4'd2,
        K_SEND_WA = 4'd3,
        K_SEND_D  = 4'd4,
        K_SEND_AR = 4'd5,
        K_ACK     = 4'd6,
        K_READ    = 4'd7,
        K_NACK    = 4'd8,
        K_STOP    = 4'd9
    } kind_t;

    // Configuration register contents
    typedef struct packed {
        logic [6:0] dev_addr;
        logic [7:0] word_addr;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_missing;
    } result_t;

    // Phase kind at a program position; position zero means idle
    function automatic kind_t kind_at(input logic [3:0] pos, input logic rd);
        kind_t k;
        case (pos)
            4'd1:    k = K_START;
            4'd2:    k = K_SEND_AW;
            4'd3:    k = K_ACK;
            4'd4:    k = K_SEND_WA;
            4'd5:    k = K_ACK;
            4'd6:    k = rd ? K_START   : K_SEND_D;
            4'd7:    k = rd ? K_SEND_AR : K_ACK;
            4'd8:    k = rd ? K_ACK     : K_STOP;
            4'd9:    k = rd ? K_READ    : K_NONE;
            4'd10:   k = rd ? K_NACK    : K_NONE;
            4'd11:   k = rd ? K_STOP    : K_NONE;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/i2cee_cfg.sv =====
// APB-style configuration registers: device address and word address.
`timescale 1ns / 1ps

module i2cee_cfg
    import i2cee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [6:0] dev_addr_reg;
    logic [7:0] word_addr_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= DEV_ADDR_RESET;
            word_addr_reg <= WORD_ADDR_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_DEV_ADDR:  dev_addr_reg  <= pwdata[6:0];
                REG_WORD_ADDR: word_addr_reg <= pwdata[7:0];
                default:       dev_addr_reg  <= dev_addr_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (paddr[2])
            REG_DEV_ADDR:  prdata = {25'd0, dev_addr_reg};
            REG_WORD_ADDR: prdata = {24'd0, word_addr_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.dev_addr  = dev_addr_reg;
    assign cfg.word_addr = word_addr_reg;

endmodule

// ===== hdl/i2cee_seq.sv =====
// Bus sequencer: transaction state and one pin step per accepted item.
`timescale 1ns / 1ps

module i2cee_seq
    import i2cee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [1:0] operation,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output result_t    res
);

    // Sequence state
    logic [3:0] pos_reg,   pos_next;
    logic [1:0] sub_reg,   sub_next;
    logic [2:0] bc_reg,    bc_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] hold_reg,  hold_next;
    logic       rd_reg,    rd_next;
    logic       fail_reg,  fail_next;
    logic       scl_reg,   scl_next;
    logic       sda_reg,   sda_next;
    logic [7:0] rres_reg,  rres_next;

    // State as seen after a possible start request
    logic       start;
    logic [3:0] e_pos;
    logic [1:0] e_sub;
    logic [2:0] e_bc;
    kind_t      kind;
    kind_t      kind_following;
    logic       adv;
    logic       done;
    logic [7:0] shift_in;

    assign start = (pos_reg == 4'd0) && ((operation == OP_WRITE) || (operation == OP_READ));

    always_comb
    begin
        e_pos     = start ? 4'd1 : pos_reg;
        e_sub     = start ? 2'd0 : sub_reg;
        e_bc      = start ? 3'd0 : bc_reg;
        rd_next   = start ? (operation == OP_READ) : rd_reg;
        hold_next = (start && (operation == OP_WRITE)) ? write_data : hold_reg;
        kind           = kind_at(e_pos, rd_next);
        kind_following = kind_at(e_pos + 4'd1, rd_next);
        shift_in       = {shift_reg[6:0], sda_in};
    end

    // Next sequence state
    always_comb
    begin
        pos_next   = e_pos;
        sub_next   = e_sub + 2'd1;
        bc_next    = e_bc;
        shift_next = shift_reg;
        fail_next  = start ? 1'b0 : fail_reg;
        rres_next  = rres_reg;
        adv        = 1'b0;
        case (kind)
            K_START:
            begin
                adv = (e_sub == 2'd3);
            end
            K_SEND_AW, K_SEND_WA, K_SEND_D, K_SEND_AR:
            begin
                if (e_sub[1])
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bc_next    = e_bc + 3'd1;
                    if (e_bc == 3'd7)
                        adv = 1'b1;
                    else
                        sub_next = 2'd0;
                end
            end
            K_ACK:
            begin
                if ((e_sub == 2'd2) && sda_in)
                    fail_next = 1'b1;
                adv = (e_sub == 2'd3);
            end
            K_READ:
            begin
                if (e_sub[1])
                begin
                    shift_next = shift_in;
                    bc_next    = e_bc + 3'd1;
                    if (e_bc == 3'd7)
                    begin
                        rres_next = shift_in;
                        adv       = 1'b1;
                    end
                    else
                        sub_next = 2'd0;
                end
            end
            K_NACK:
            begin
                adv = (e_sub == 2'd3);
            end
            K_STOP:
            begin
                if (e_sub[1])
                begin
                    pos_next = 4'd0;
                    sub_next = 2'd0;
                    bc_next  = 3'd0;
                end
            end
            default:
            begin
                pos_next = 4'd0;
                sub_next = 2'd0;
            end
        endcase

        // Enter the following phase and load its byte
        if (adv)
        begin
            bc_next  = 3'd0;
            sub_next = 2'd0;
            if (kind_following == K_NONE)
                pos_next = 4'd0;
            else
                pos_next = e_pos + 4'd1;
            case (kind_following)
                K_SEND_AW: shift_next = {cfg.dev_addr, 1'b0};
                K_SEND_AR: shift_next = {cfg.dev_addr, 1'b1};
                K_SEND_WA: shift_next = cfg.word_addr;
                K_SEND_D:  shift_next = hold_next;
                K_READ:    shift_next = 8'd0;
                default:   shift_next = shift_next;
            endcase
        end
    end

    // Pin levels and stop completion
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        done     = 1'b0;
        case (kind)
            K_START:
            begin
                case (e_sub)
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
            end
            K_SEND_AW, K_SEND_WA, K_SEND_D, K_SEND_AR:
            begin
                case (e_sub)
                    2'd0:    sda_next = shift_reg[7];
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            K_ACK, K_NACK:
            begin
                case (e_sub)
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    scl_next = 1'b0;
                    default: sda_next = 1'b0;
                endcase
            end
            K_READ:
            begin
                case (e_sub)
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            K_STOP:
            begin
                case (e_sub)
                    2'd0:    sda_next = 1'b0;
                    2'd1:    scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                endcase
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            sub_reg   <= 2'd0;
            bc_reg    <= 3'd0;
            shift_reg <= 8'd0;
            hold_reg  <= 8'd0;
            rd_reg    <= 1'b0;
            fail_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rres_reg  <= 8'd0;
        end
        else if (step_en)
        begin
            pos_reg   <= pos_next;
            sub_reg   <= sub_next;
            bc_reg    <= bc_next;
            shift_reg <= shift_next;
            hold_reg  <= hold_next;
            rd_reg    <= rd_next;
            fail_reg  <= fail_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rres_reg  <= rres_next;
        end
    end

    // Result of this item's step
    assign res.scl         = scl_next;
    assign res.sda         = sda_next;
    assign res.busy        = (pos_next != 4'd0);
    assign res.done        = done;
    assign res.read_data   = rres_next;
    assign res.ack_missing = fail_next;

endmodule

// ===== hdl/i2c_eeprom_byte_access_master.sv =====
// Top level of the I2C EEPROM byte-write / random-read master.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid, in_stall  | operation, write_data, sda_in
//  out     | out_valid, out_stall| scl_level, sda_level, busy_res, done_res,
//          |                     | read_data, ack_missing
//  cfg     | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// One item per clock unless stalled: each item performs one pin step in a single
// pass from the sequence state registers to the result register, so its result
// appears the cycle after acceptance. The result register decouples the sides;
// the input is stalled only while a result is held and the output is stalled.
// Reset (rst_n low) returns the sequencer to idle with both bus lines high.
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_master
    import i2cee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_missing,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    // Hold the input while an untaken result sits in the output register
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    i2cee_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cee_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .operation  (operation),
        .write_data (write_data),
        .sda_in     (sda_in),
        .cfg        (cfg),
        .res        (step_res)
    );

    // Track result occupancy
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Capture the result of each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign scl_level   = res_reg.scl;
    assign sda_level   = res_reg.sda;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign read_data   = res_reg.read_data;
    assign ack_missing = res_reg.ack_missing;

endmodule

// ===== sim/tb_i2c_eeprom_byte_access_master.sv =====
// Testbench: I2C EEPROM byte-write / random-read master against a cycle-accurate pin predictor.
`timescale 1ns / 1ps

module tb_i2c_eeprom_byte_access_master;
    import i2cee_pkg::*;

    // Operation code 3 has no meaning and acts as a plain tick
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Ticks from request to stop for each transfer kind
    localparam int WRITE_TICKS = 91;
    localparam int READ_TICKS  = 123;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0] op;
        logic [7:0] wdata;
        logic       sda;
    } tick_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_TICK;
    logic [7:0]  write_data = 8'd0;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_data;
    logic        ack_missing;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    tick_item_t  pending_ticks[$];
    result_t     expected_pins[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        idle_on = 1'b1;
    int          sda_high_pcts[5] = '{0, 12, 50, 88, 100};

    // Predictor copy of registers and sequencer state
    logic [6:0]  cfg_dev = DEV_ADDR_RESET;
    logic [7:0]  cfg_word = WORD_ADDR_RESET;
    logic [3:0]  seq_pos = 4'd0;
    logic [1:0]  seq_sub = 2'd0;
    logic [2:0]  bit_cnt = 3'd0;
    logic [7:0]  shift_q = 8'd0;
    logic [7:0]  wdata_hold = 8'd0;
    logic        rd_mode = 1'b0;
    logic        ack_miss = 1'b0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic [7:0]  last_read = 8'd0;

    i2c_eeprom_byte_access_master dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .write_data (write_data),
        .sda_in     (sda_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_data  (read_data),
        .ack_missing(ack_missing),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // Phase kind at a program position for the transfer in progress
    function automatic kind_t phase_kind(input logic [3:0] pos);
        kind_t k;
        k = K_NONE;
        if (rd_mode)
        begin
            case (pos)
                4'd1, 4'd6:         k = K_START;
                4'd2:               k = K_SEND_AW;
                4'd3, 4'd5, 4'd8:   k = K_ACK;
                4'd4:               k = K_SEND_WA;
                4'd7:               k = K_SEND_AR;
                4'd9:               k = K_READ;
                4'd10:              k = K_NACK;
                4'd11:              k = K_STOP;
                default:            k = K_NONE;
            endcase
        end
        else
        begin
            case (pos)
                4'd1:               k = K_START;
                4'd2:               k = K_SEND_AW;
                4'd3, 4'd5, 4'd7:   k = K_ACK;
                4'd4:               k = K_SEND_WA;
                4'd6:               k = K_SEND_D;
                4'd8:               k = K_STOP;
                default:            k = K_NONE;
            endcase
        end
        return k;
    endfunction

    // Enter a phase; address bytes take the register value at this moment
    function automatic void enter_phase(input logic [3:0] pos);
        kind_t k;
        k = phase_kind(pos);
        bit_cnt = 3'd0;
        seq_sub = 2'd0;
        if (k == K_NONE)
            seq_pos = 4'd0;
        else
        begin
            seq_pos = pos;
            case (k)
                K_SEND_AW: shift_q = {cfg_dev, 1'b0};
                K_SEND_AR: shift_q = {cfg_dev, 1'b1};
                K_SEND_WA: shift_q = cfg_word;
                K_SEND_D:  shift_q = wdata_hold;
                K_READ:    shift_q = 8'd0;
                default:   ;
            endcase
        end
    endfunction

    // Perform one pin step; return high when the stop condition completes
    function automatic logic run_pin_step(input logic sda);
        kind_t      k;
        logic [1:0] nsub;
        logic       adv;
        k = phase_kind(seq_pos);
        nsub = seq_sub + 2'd1;
        adv = 1'b0;
        case (k)
            K_START:
                case (seq_sub)
                    2'd0:    sda_q = 1'b1;
                    2'd1:    scl_q = 1'b1;
                    2'd2:    sda_q = 1'b0;
                    default:
                    begin
                        scl_q = 1'b0;
                        adv = 1'b1;
                    end
                endcase
            K_SEND_AW, K_SEND_WA, K_SEND_D, K_SEND_AR:
                if (seq_sub == 2'd0)
                    sda_q = shift_q[7];
                else if (seq_sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    scl_q = 1'b0;
                    shift_q = {shift_q[6:0], 1'b0};
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0)
                        adv = 1'b1;
                    else
                        nsub = 2'd0;
                end
            K_ACK, K_NACK:
                case (seq_sub)
                    2'd0:    sda_q = 1'b1;
                    2'd1:    scl_q = 1'b1;
                    2'd2:
                    begin
                        // only a real ack slot checks the slave
                        if (k == K_ACK && sda)
                            ack_miss = 1'b1;
                        scl_q = 1'b0;
                    end
                    default:
                    begin
                        sda_q = 1'b0;
                        adv = 1'b1;
                    end
                endcase
            K_READ:
                if (seq_sub == 2'd0)
                    sda_q = 1'b1;
                else if (seq_sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    shift_q = {shift_q[6:0], sda};
                    scl_q = 1'b0;
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 3'd0)
                    begin
                        last_read = shift_q;
                        adv = 1'b1;
                    end
                    else
                        nsub = 2'd0;
                end
            K_STOP:
                if (seq_sub == 2'd0)
                    sda_q = 1'b0;
                else if (seq_sub == 2'd1)
                    scl_q = 1'b1;
                else
                begin
                    sda_q = 1'b1;
                    seq_pos = 4'd0;
                    seq_sub = 2'd0;
                    bit_cnt = 3'd0;
                    return 1'b1;
                end
            default:
            begin
                seq_pos = 4'd0;
                seq_sub = 2'd0;
                return 1'b0;
            end
        endcase
        if (adv)
            enter_phase(seq_pos + 4'd1);
        else
            seq_sub = nsub;
        return 1'b0;
    endfunction

    // Expected pin levels and status after one accepted tick
    function automatic result_t predict_tick(input logic [1:0] op, input logic [7:0] wd,
                                             input logic sda);
        result_t r;
        logic    stop_done;
        stop_done = 1'b0;
        // take a request only when idle
        if (seq_pos == 4'd0 && (op == OP_WRITE || op == OP_READ))
        begin
            rd_mode = (op == OP_READ);
            if (op == OP_WRITE)
                wdata_hold = wd;
            ack_miss = 1'b0;
            enter_phase(4'd1);
        end
        if (seq_pos != 4'd0)
            stop_done = run_pin_step(sda);
        r.scl = scl_q;
        r.sda = sda_q;
        r.busy = (seq_pos != 4'd0);
        r.done = stop_done;
        r.read_data = last_read;
        r.ack_missing = ack_miss;
        return r;
    endfunction

    task automatic push_tick(input logic [1:0] op, input logic [7:0] wd, input logic sda);
        tick_item_t t;
        t.op = op;
        t.wdata = wd;
        t.sda = sda;
        pending_ticks.push_back(t);
    endtask

    // Queue ticks of a running transfer, with the odd ignored request mixed in
    task automatic push_busy_ticks(input int count, input int high_pct);
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
            push_tick(op, 8'($urandom), $urandom_range(0, 99) < high_pct);
        end
    endtask

    // Wait until the sender is empty and every expected item has come back
    task automatic wait_all_results();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_pins.size() != 0);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_DEV_ADDR)
            cfg_dev = value[6:0];
        else
            cfg_word = value;
        @(negedge clk);
    endtask

    // Queue one well-formed transfer; optionally pause at a random point and change both registers
    task automatic run_transfer(input logic rd, input logic reconfig);
        int total;
        int part;
        int pct;
        total = rd ? READ_TICKS : WRITE_TICKS;
        pct = sda_high_pcts[$urandom_range(0, 4)];
        part = reconfig ? $urandom_range(1, total - 2) : total - 1;
        push_tick(rd ? OP_READ : OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
        push_busy_ticks(part, pct);
        if (reconfig)
        begin
            wait_all_results();
            write_reg(REG_DEV_ADDR, 8'($urandom_range(0, 127)));
            write_reg(REG_WORD_ADDR, 8'($urandom));
            push_busy_ticks(total - 1 - part, pct);
        end
        repeat ($urandom_range(0, 3))
            push_tick(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_TICK, 8'($urandom),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string label, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h got %0h", $time, label, want_v, got_v);
            error_count = error_count + 1;
        end
    endtask

    // Present queued items; hold while stalled, insert random gaps after acceptance
    always @(posedge clk)
    begin : drive_ticks
        tick_item_t nxt;
        logic       took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
                expected_pins.push_back(predict_tick(operation, write_data, sda_in));
            if (took || !in_valid)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (took && idle_on && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= $urandom_range(0, 2);
                end
                else if (pending_ticks.size() != 0)
                begin
                    nxt = pending_ticks.pop_front();
                    operation <= nxt.op;
                    write_data <= nxt.wdata;
                    sda_in <= nxt.sda;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in short random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pins.size() == 0)
            begin
                $display("%0t: result with nothing expected, got scl %0b sda %0b busy %0b",
                         $time, scl_level, sda_level, busy_res);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_pins.pop_front();
                check_field("scl_level", 8'(want.scl), 8'(scl_level));
                check_field("sda_level", 8'(want.sda), 8'(sda_level));
                check_field("busy_res", 8'(want.busy), 8'(busy_res));
                check_field("done_res", 8'(want.done), 8'(done_res));
                check_field("read_data", want.read_data, read_data);
                check_field("ack_missing", 8'(want.ack_missing), 8'(ack_missing));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Idle ticks, plain and spare code, under reset register values
        push_tick(OP_TICK, 8'h00, 1'b0);
        push_tick(OP_SPARE, 8'hFF, 1'b1);
        push_tick(OP_TICK, 8'hFF, 1'b1);
        // Byte write of all ones, then requests that must be ignored while busy
        push_tick(OP_WRITE, 8'hFF, 1'b0);
        repeat (4)
        begin
            push_tick(OP_READ, 8'h00, 1'b0);
            push_tick(OP_WRITE, 8'hFF, 1'b1);
            push_tick(OP_SPARE, 8'h00, 1'b1);
            push_tick(OP_TICK, 8'hFF, 1'b0);
        end
        // Pause mid-write and move both registers to their top values
        wait_all_results();
        write_reg(REG_DEV_ADDR, 8'd127);
        write_reg(REG_WORD_ADDR, 8'd255);
        push_busy_ticks(WRITE_TICKS - 17, 0);
        push_tick(OP_TICK, 8'h00, 1'b1);
        push_tick(OP_TICK, 8'h00, 1'b0);
        wait_all_results();

        // Random transfers over several register settings
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_DEV_ADDR, 8'd0);
                    write_reg(REG_WORD_ADDR, 8'd0);
                end
                1:
                begin
                    write_reg(REG_DEV_ADDR, 8'd127);
                    write_reg(REG_WORD_ADDR, 8'd0);
                end
                2:
                begin
                    write_reg(REG_DEV_ADDR, 8'd0);
                    write_reg(REG_WORD_ADDR, 8'd255);
                end
                default:
                begin
                    write_reg(REG_DEV_ADDR, 8'($urandom_range(0, 127)));
                    write_reg(REG_WORD_ADDR, 8'($urandom));
                end
            endcase
            // drop all idling in the last phase
            idle_on = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_transfer(ph[0], 1'b0);
            run_transfer(1'($urandom_range(0, 1)), 1'b1);
            // noise: any code, may start an extra transfer
            repeat ($urandom_range(0, 4))
                push_tick(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
            wait_all_results();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/i2cee_pkg.sv
hdl/i2cee_cfg.sv
hdl/i2cee_seq.sv
hdl/i2c_eeprom_byte_access_master.sv
sim/tb_i2c_eeprom_byte_access_master.sv
